### sv/rro_pkg.sv
package rro_pkg;

  localparam int unsigned AngleBits   = 9;
  localparam int unsigned SinTabDepth = 91;
  localparam int unsigned SinTabWidth = 25;
  localparam int unsigned QueueDepth  = 4;

  localparam longint unsigned PiQ30 = 64'd3373259426;
  localparam longint unsigned TaylorDiv [8] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
  };

  typedef logic [SinTabWidth-1:0] sin_tab_t [SinTabDepth];

  typedef struct packed {
    logic       neg;
    logic [6:0] idx;
  } trig_sel_t;

  // quarter-wave sine, Q1.frac, Taylor series on a Q2.30 argument
  function automatic sin_tab_t sin_table(input int unsigned frac);
    sin_tab_t          tab;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint            sum;
    for (int unsigned d = 0; d < SinTabDepth; d++) begin
      x    = (longint'(d) * PiQ30 + 64'd90) / 64'd180;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int unsigned k = 1; k <= 8; k++) begin
        term = (term * x2) >> 30;
        term = term / TaylorDiv[k-1];
        if (k[0]) sum = sum - longint'(term);
        else      sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > (longint'(1) << 30)) sum = longint'(1) << 30;
      tab[d] = SinTabWidth'((sum + (longint'(1) << (29 - frac))) >>> (30 - frac));
    end
    return tab;
  endfunction

  // angle in 0..359 -> table index and sign
  function automatic trig_sel_t trig_sel(input logic [AngleBits-1:0] a);
    trig_sel_t             t;
    logic [AngleBits-1:0]  i;
    if (a <= 9'd90) begin
      i     = a;
      t.neg = 1'b0;
    end else if (a <= 9'd180) begin
      i     = 9'd180 - a;
      t.neg = 1'b0;
    end else if (a <= 9'd270) begin
      i     = a - 9'd180;
      t.neg = 1'b1;
    end else begin
      i     = 9'd360 - a;
      t.neg = 1'b1;
    end
    t.idx = i[6:0];
    return t;
  endfunction

endpackage

### sv/rro_mul.sv
module rro_mul #(
  parameter int unsigned AWidth = 32,
  parameter int unsigned BWidth = 32
) (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic signed [AWidth-1:0]         a_i,
  input  logic signed [BWidth-1:0]         b_i,
  output logic signed [AWidth+BWidth-1:0]  p_o
);

  localparam int unsigned AL = AWidth / 2;
  localparam int unsigned AH = AWidth - AL;
  localparam int unsigned BL = BWidth / 2;
  localparam int unsigned BH = BWidth - BL;
  localparam int unsigned PW = AWidth + BWidth;

  logic signed [AH+BH-1:0]   hh_q;
  logic signed [AH+BL:0]     hl_q;
  logic signed [AL+BH:0]     lh_q;
  logic        [AL+BL-1:0]   ll_q;
  logic signed [PW-1:0]      p_q;
  logic signed [PW-1:0]      ehh, ehl, elh, ell, p_d;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hh_q <= $signed(a_i[AWidth-1:AL]) * $signed(b_i[BWidth-1:BL]);
      hl_q <= $signed(a_i[AWidth-1:AL]) * $signed({1'b0, b_i[BL-1:0]});
      lh_q <= $signed({1'b0, a_i[AL-1:0]}) * $signed(b_i[BWidth-1:BL]);
      ll_q <= a_i[AL-1:0] * b_i[BL-1:0];
      p_q  <= p_d;
    end
  end

  always_comb begin
    ehh = PW'(hh_q);
    ehl = PW'(hl_q);
    elh = PW'(lh_q);
    ell = $signed({{(PW-AL-BL){1'b0}}, ll_q});
    p_d = (ehh <<< (AL + BL)) + (ehl <<< AL) + (elh <<< BL) + ell;
  end

  assign p_o = p_q;

endmodule

### sv/rro_front.sv
module rro_front #(
  parameter int unsigned CoordBits    = 32,
  parameter int unsigned TrigFracBits = 15,
  parameter int unsigned DataBits     = 272
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_valid_i,
  output logic                          s_ready_o,
  input  logic [DataBits-1:0]           s_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [CoordBits+1:0]   cx_o  [2],
  output logic signed [CoordBits+1:0]   cy_o  [2],
  output logic [CoordBits-2:0]          w_o   [2],
  output logic [CoordBits-2:0]          h_o   [2],
  output logic signed [TrigFracBits+1:0] sin_o [2],
  output logic signed [TrigFracBits+1:0] cos_o [2]
);
  import rro_pkg::*;

  localparam int unsigned PosW     = CoordBits + 2;
  localparam int unsigned TrigW    = TrigFracBits + 2;
  localparam int unsigned RectBits = 4 * CoordBits - 2 + AngleBits;
  localparam sin_tab_t    SinTab   = sin_table(TrigFracBits);

  function automatic logic signed [TrigW-1:0] trig_val(input trig_sel_t t);
    logic signed [TrigW-1:0] mag;
    mag = $signed({1'b0, SinTab[t.idx][TrigFracBits:0]});
    return t.neg ? -mag : mag;
  endfunction

  logic valid_q;
  logic adv;

  logic signed [PosW-1:0]  cx_q  [2];
  logic signed [PosW-1:0]  cy_q  [2];
  logic [CoordBits-2:0]    w_q   [2];
  logic [CoordBits-2:0]    h_q   [2];
  logic signed [TrigW-1:0] sin_q [2];
  logic signed [TrigW-1:0] cos_q [2];

  assign adv         = !valid_q || out_ready_i;
  assign s_ready_o   = adv;
  assign out_valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= s_valid_i;
    end
  end

  for (genvar r = 0; r < 2; r++) begin : g_rect
    logic signed [CoordBits-1:0] left, top;
    logic [CoordBits-2:0]        wd, ht;
    logic [AngleBits-1:0]        ang, ar, cr;
    logic [AngleBits:0]          cb;

    assign left = $signed(s_data_i[r*RectBits +: CoordBits]);
    assign top  = $signed(s_data_i[r*RectBits + CoordBits +: CoordBits]);
    assign wd   = s_data_i[r*RectBits + 2*CoordBits +: CoordBits-1];
    assign ht   = s_data_i[r*RectBits + 3*CoordBits - 1 +: CoordBits-1];
    assign ang  = s_data_i[r*RectBits + 4*CoordBits - 2 +: AngleBits];
    assign ar   = (ang >= 9'd360) ? ang - 9'd360 : ang;
    assign cb   = {1'b0, ar} + 10'd90;
    assign cr   = (cb >= 10'd360) ? AngleBits'(cb - 10'd360) : AngleBits'(cb);

    always_ff @(posedge clk_i) begin
      if (adv && s_valid_i) begin
        cx_q[r]  <= (PosW'(left) <<< 1) + $signed({3'b000, wd});
        cy_q[r]  <= (PosW'(top) <<< 1) + $signed({3'b000, ht});
        w_q[r]   <= wd;
        h_q[r]   <= ht;
        sin_q[r] <= trig_val(trig_sel(ar));
        cos_q[r] <= trig_val(trig_sel(cr));
      end
    end

    assign cx_o[r]  = cx_q[r];
    assign cy_o[r]  = cy_q[r];
    assign w_o[r]   = w_q[r];
    assign h_o[r]   = h_q[r];
    assign sin_o[r] = sin_q[r];
    assign cos_o[r] = cos_q[r];
  end

endmodule

### sv/rro_fifo.sv
module rro_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             ready_o,
  input  logic [Width-1:0] data_i,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign ready_o = cnt_q != CntW'(Depth);
  assign valid_o = cnt_q != '0;
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

### sv/rro_back.sv
module rro_back #(
  parameter int unsigned CoordBits    = 32,
  parameter int unsigned TrigFracBits = 15
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [CoordBits+1:0]    cx_i  [2],
  input  logic signed [CoordBits+1:0]    cy_i  [2],
  input  logic [CoordBits-2:0]           w_i   [2],
  input  logic [CoordBits-2:0]           h_i   [2],
  input  logic signed [TrigFracBits+1:0] sin_i [2],
  input  logic signed [TrigFracBits+1:0] cos_i [2],
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           overlap_o
);

  localparam int unsigned PosW  = CoordBits + 2;
  localparam int unsigned TrigW = TrigFracBits + 2;
  localparam int unsigned LenW  = CoordBits;
  localparam int unsigned RotW  = TrigW + LenW;
  localparam int unsigned SumW  = RotW + 2;
  localparam int unsigned OffW  = CoordBits + 2;
  localparam int unsigned CrnW  = CoordBits + 3;
  localparam int unsigned AxW   = CoordBits + 4;
  localparam int unsigned PrjW  = CrnW + AxW;
  localparam int unsigned ValW  = PrjW + 1;
  localparam int unsigned NStg  = 11;

  localparam logic signed [SumW-1:0] RndHalf =
    {{(SumW-TrigFracBits){1'b0}}, 1'b1, {(TrigFracBits-1){1'b0}}};
  // corner order: left top, left bottom, right bottom, right top
  localparam bit DxNeg [4] = '{1'b1, 1'b1, 1'b0, 1'b0};
  localparam bit DyNeg [4] = '{1'b1, 1'b0, 1'b0, 1'b1};

  logic            adv;
  logic [NStg-1:0] vld_q;
  logic            out_valid_q, overlap_q, overlap_d;

  logic signed [PosW-1:0]  cx0_q [2], cy0_q [2], cx1_q [2], cy1_q [2];
  logic signed [PosW-1:0]  cx2_q [2], cy2_q [2], cx3_q [2], cy3_q [2];
  logic signed [LenW-1:0]  w0_q [2], h0_q [2];
  logic signed [TrigW-1:0] s0_q [2], c0_q [2];
  logic signed [RotW-1:0]  cw_p [2], sw_p [2], ch_p [2], sh_p [2];
  logic signed [OffW-1:0]  ox_d [2][4], oy_d [2][4], ox3_q [2][4], oy3_q [2][4];
  logic signed [CrnW-1:0]  kx4_q [2][4], ky4_q [2][4], kx5_q [2][4], ky5_q [2][4];
  logic signed [AxW-1:0]   ax_d [4], ay_d [4], ax5_q [4], ay5_q [4];
  logic [3:0]              nz5_q, nz6_q, nz7_q, nz8_q, nz9_q, nz10_q;
  logic signed [PrjW-1:0]  px_p [4][2][4], py_p [4][2][4];
  logic signed [ValW-1:0]  v8_q [4][2][4];
  logic signed [ValW-1:0]  mn9_q [4][2][2], mx9_q [4][2][2];
  logic signed [ValW-1:0]  mn10_q [4][2], mx10_q [4][2];

  assign adv         = !out_valid_q || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = out_valid_q;
  assign overlap_o   = overlap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[NStg-2:0], in_valid_i};
      out_valid_q <= vld_q[NStg-1];
    end
  end

  for (genvar r = 0; r < 2; r++) begin : g_rot
    rro_mul #(.AWidth(TrigW), .BWidth(LenW)) u_cw (
      .clk_i, .en_i(adv), .a_i(c0_q[r]), .b_i(w0_q[r]), .p_o(cw_p[r]));
    rro_mul #(.AWidth(TrigW), .BWidth(LenW)) u_sw (
      .clk_i, .en_i(adv), .a_i(s0_q[r]), .b_i(w0_q[r]), .p_o(sw_p[r]));
    rro_mul #(.AWidth(TrigW), .BWidth(LenW)) u_ch (
      .clk_i, .en_i(adv), .a_i(c0_q[r]), .b_i(h0_q[r]), .p_o(ch_p[r]));
    rro_mul #(.AWidth(TrigW), .BWidth(LenW)) u_sh (
      .clk_i, .en_i(adv), .a_i(s0_q[r]), .b_i(h0_q[r]), .p_o(sh_p[r]));
  end

  for (genvar j = 0; j < 4; j++) begin : g_ax
    for (genvar r = 0; r < 2; r++) begin : g_rc
      for (genvar i = 0; i < 4; i++) begin : g_cr
        rro_mul #(.AWidth(CrnW), .BWidth(AxW)) u_px (
          .clk_i, .en_i(adv), .a_i(kx5_q[r][i]), .b_i(ax5_q[j]), .p_o(px_p[j][r][i]));
        rro_mul #(.AWidth(CrnW), .BWidth(AxW)) u_py (
          .clk_i, .en_i(adv), .a_i(ky5_q[r][i]), .b_i(ay5_q[j]), .p_o(py_p[j][r][i]));
      end
    end
  end

  // rotated corner offsets, rounded half up
  always_comb begin
    logic signed [SumW-1:0] tx, ty;
    for (int r = 0; r < 2; r++) begin
      for (int i = 0; i < 4; i++) begin
        tx = (DxNeg[i] ? -SumW'(cw_p[r]) : SumW'(cw_p[r]))
           + (DyNeg[i] ? SumW'(sh_p[r]) : -SumW'(sh_p[r])) + RndHalf;
        ty = (DxNeg[i] ? -SumW'(sw_p[r]) : SumW'(sw_p[r]))
           + (DyNeg[i] ? -SumW'(ch_p[r]) : SumW'(ch_p[r])) + RndHalf;
        ox_d[r][i] = OffW'(tx >>> TrigFracBits);
        oy_d[r][i] = OffW'(ty >>> TrigFracBits);
      end
    end
  end

  // axes: top edge and right edge of each rectangle
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      ax_d[j] = AxW'(kx4_q[j/2][3]) - AxW'(kx4_q[j/2][(j % 2 == 1) ? 2 : 0]);
      ay_d[j] = AxW'(ky4_q[j/2][3]) - AxW'(ky4_q[j/2][(j % 2 == 1) ? 2 : 0]);
    end
  end

  always_comb begin
    logic sep;
    overlap_d = 1'b1;
    for (int j = 0; j < 4; j++) begin
      sep = (mx10_q[j][0] < mn10_q[j][1]) || (mx10_q[j][1] < mn10_q[j][0]);
      if (!nz10_q[j] || sep) overlap_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 2; r++) begin
        cx0_q[r] <= cx_i[r];
        cy0_q[r] <= cy_i[r];
        w0_q[r]  <= $signed({1'b0, w_i[r]});
        h0_q[r]  <= $signed({1'b0, h_i[r]});
        s0_q[r]  <= sin_i[r];
        c0_q[r]  <= cos_i[r];
        cx1_q[r] <= cx0_q[r];
        cy1_q[r] <= cy0_q[r];
        cx2_q[r] <= cx1_q[r];
        cy2_q[r] <= cy1_q[r];
        cx3_q[r] <= cx2_q[r];
        cy3_q[r] <= cy2_q[r];
        for (int i = 0; i < 4; i++) begin
          ox3_q[r][i] <= ox_d[r][i];
          oy3_q[r][i] <= oy_d[r][i];
          kx4_q[r][i] <= CrnW'(cx3_q[r]) + CrnW'(ox3_q[r][i]);
          ky4_q[r][i] <= CrnW'(cy3_q[r]) + CrnW'(oy3_q[r][i]);
          kx5_q[r][i] <= kx4_q[r][i];
          ky5_q[r][i] <= ky4_q[r][i];
        end
      end
      for (int j = 0; j < 4; j++) begin
        ax5_q[j] <= ax_d[j];
        ay5_q[j] <= ay_d[j];
        nz5_q[j] <= (ax_d[j] != '0) || (ay_d[j] != '0);
        for (int r = 0; r < 2; r++) begin
          for (int i = 0; i < 4; i++) begin
            v8_q[j][r][i] <= ValW'(px_p[j][r][i]) + ValW'(py_p[j][r][i]);
          end
          for (int p = 0; p < 2; p++) begin
            mn9_q[j][r][p] <= (v8_q[j][r][2*p] < v8_q[j][r][2*p+1]) ?
                              v8_q[j][r][2*p] : v8_q[j][r][2*p+1];
            mx9_q[j][r][p] <= (v8_q[j][r][2*p] < v8_q[j][r][2*p+1]) ?
                              v8_q[j][r][2*p+1] : v8_q[j][r][2*p];
          end
          mn10_q[j][r] <= (mn9_q[j][r][0] < mn9_q[j][r][1]) ?
                          mn9_q[j][r][0] : mn9_q[j][r][1];
          mx10_q[j][r] <= (mx9_q[j][r][0] < mx9_q[j][r][1]) ?
                          mx9_q[j][r][1] : mx9_q[j][r][0];
        end
      end
      nz6_q     <= nz5_q;
      nz7_q     <= nz6_q;
      nz8_q     <= nz7_q;
      nz9_q     <= nz8_q;
      nz10_q    <= nz9_q;
      overlap_q <= overlap_d;
    end
  end

endmodule

### sv/rotated_rect_overlap_test.sv
// Separating-axis overlap test of two rotated rectangles. Each input transfer
// carries two rectangles (left, top, width, height in Q16.16, rotation in whole
// degrees about the centre); each produces one output transfer whose bit 0 is
// 1 when the rotated rectangles intersect (touching counts) and 0 when some
// edge axis separates them or an edge has zero length. One transfer is taken
// per clock unless a side stalls; the front stage, the four-entry queue and the
// back pipeline of 72 two-stage multipliers lie between input and output.
// Either side may stall on its own.
module rotated_rect_overlap_test #(
  parameter int unsigned COORD_BITS     = 32,
  parameter int unsigned TRIG_FRAC_BITS = 15
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         s_axis_tvalid,
  output logic                                         s_axis_tready,
  // a_left, a_top, a_width, a_height, a_angle, b_left, b_top, b_width,
  // b_height, b_angle
  input  logic [((8*COORD_BITS+14+7)/8)*8-1:0]         s_axis_tdata,
  output logic                                         m_axis_tvalid,
  input  logic                                         m_axis_tready,
  // overlap
  output logic [7:0]                                   m_axis_tdata
);
  import rro_pkg::*;

  localparam int unsigned DataBits  = ((8*COORD_BITS + 14 + 7) / 8) * 8;
  localparam int unsigned PosW      = COORD_BITS + 2;
  localparam int unsigned TrigW     = TRIG_FRAC_BITS + 2;
  localparam int unsigned EntryRect = 2*PosW + 2*(COORD_BITS-1) + 2*TrigW;

  logic                        f_valid, q_ready, q_valid, b_ready, overlap;
  logic signed [PosW-1:0]      f_cx [2], f_cy [2], b_cx [2], b_cy [2];
  logic [COORD_BITS-2:0]       f_w [2], f_h [2], b_w [2], b_h [2];
  logic signed [TrigW-1:0]     f_s [2], f_c [2], b_s [2], b_c [2];
  logic [2*EntryRect-1:0]      q_in, q_out;

  rro_front #(
    .CoordBits(COORD_BITS), .TrigFracBits(TRIG_FRAC_BITS), .DataBits(DataBits)
  ) u_front (
    .clk_i, .rst_ni,
    .s_valid_i(s_axis_tvalid), .s_ready_o(s_axis_tready), .s_data_i(s_axis_tdata),
    .out_valid_o(f_valid), .out_ready_i(q_ready),
    .cx_o(f_cx), .cy_o(f_cy), .w_o(f_w), .h_o(f_h), .sin_o(f_s), .cos_o(f_c)
  );

  for (genvar r = 0; r < 2; r++) begin : g_pack
    assign q_in[r*EntryRect +: EntryRect] = {f_c[r], f_s[r], f_h[r], f_w[r], f_cy[r], f_cx[r]};
    assign b_cx[r] = $signed(q_out[r*EntryRect +: PosW]);
    assign b_cy[r] = $signed(q_out[r*EntryRect + PosW +: PosW]);
    assign b_w[r]  = q_out[r*EntryRect + 2*PosW +: COORD_BITS-1];
    assign b_h[r]  = q_out[r*EntryRect + 2*PosW + COORD_BITS-1 +: COORD_BITS-1];
    assign b_s[r]  = $signed(q_out[r*EntryRect + 2*PosW + 2*(COORD_BITS-1) +: TrigW]);
    assign b_c[r]  = $signed(q_out[r*EntryRect + 2*PosW + 2*(COORD_BITS-1) + TrigW +: TrigW]);
  end

  rro_fifo #(.Width(2*EntryRect), .Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni,
    .push_i(f_valid), .ready_o(q_ready), .data_i(q_in),
    .valid_o(q_valid), .pop_i(b_ready), .data_o(q_out)
  );

  rro_back #(.CoordBits(COORD_BITS), .TrigFracBits(TRIG_FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .in_valid_i(q_valid), .in_ready_o(b_ready),
    .cx_i(b_cx), .cy_i(b_cy), .w_i(b_w), .h_i(b_h), .sin_i(b_s), .cos_i(b_c),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .overlap_o(overlap)
  );

  assign m_axis_tdata = {7'b0000000, overlap};

endmodule
